### sv/maw_pkg.sv
// ----------------------------------------------------------------------------
// maw_pkg
// shared types and constants of the minimum arborescence weight block
// ----------------------------------------------------------------------------
package maw_pkg;

    localparam int NV = 16;   // vertices
    localparam int VW = 4;    // vertex index width
    localparam int NW = 5;    // vertex count width
    localparam int CW = 32;   // edge cost width
    localparam int TW = 36;   // total weight width

    typedef struct packed {
        logic          live;
        logic [VW-1:0] tail;
        logic [VW-1:0] head;
        logic [CW-1:0] cost;
    } edge_rec_t;

    typedef struct packed {
        logic          clr;
        logic          set_en;
        logic [VW-1:0] set_row;
        logic [VW-1:0] set_col;
        logic          step_en;
        logic [VW-1:0] step_k;
    } clo_ctrl_t;

endpackage

### sv/maw_closure.sv
// ----------------------------------------------------------------------------
// maw_closure
// reachability matrix with clear, single-bit set and one transitive closure pivot per cycle while step_en is high
// ----------------------------------------------------------------------------
module maw_closure
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  maw_pkg::clo_ctrl_t                          ctrl,
    output logic [maw_pkg::NV-1:0][maw_pkg::NV-1:0]     rows
);

    logic [maw_pkg::NV-1:0][maw_pkg::NV-1:0] rows_reg;
    logic [maw_pkg::NV-1:0][maw_pkg::NV-1:0] rows_next;
    logic [maw_pkg::NV-1:0]                  pivot_row;

    assign pivot_row = rows_reg[ctrl.step_k];

    always_comb
    begin
        rows_next = rows_reg;
        priority if (ctrl.clr)
        begin
            rows_next = '0;
        end
        else if (ctrl.step_en)
        begin
            for (int i = 0; i < maw_pkg::NV; i++)
            begin
                if (rows_reg[i][ctrl.step_k])
                begin
                    rows_next[i] = rows_reg[i] | pivot_row;
                end
            end
        end
        else if (ctrl.set_en)
        begin
            rows_next[ctrl.set_row][ctrl.set_col] = 1'b1;
        end
        else
        begin
            rows_next = rows_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
        end
        else
        begin
            rows_reg <= rows_next;
        end
    end

    assign rows = rows_reg;

endmodule

### sv/min_arborescence_weight.sv
// ----------------------------------------------------------------------------
// min_arborescence_weight
// minimum arborescence weight of a loaded edge list (chu-liu / edmonds)
// ----------------------------------------------------------------------------
// s_* channel: one request per edge (s_tuser 0) or a solve (s_tuser 1).
// self-loops are dropped, edges past MAX_EDGES are dropped and flagged.
// a solve makes one result on m_*. a solve sweeps the edge memory once
// per pass (one edge a cycle, then the registered read drains), runs 16
// closure pivots, 16 add steps and 16 labelling steps per round, at most
// 16 rounds. s_tready is low meanwhile.
// the result waits in an output register; while m_tready is low a new
// solve finishes but holds until the register is free. edge loads are
// taken while a result waits. reset empties the edge list, clears the
// overflow flag and sets vertex_count 16, root_vertex 0.
// registers: vertex_count at 0x0, root_vertex at 0x4.
// ----------------------------------------------------------------------------
module min_arborescence_weight
#(
    parameter int MAX_EDGES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // edge_from[3:0], edge_to[7:4], edge_weight[39:8]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // total_weight[35:0], zero[39:36]
    output logic [1:0]  m_tuser,   // reachable[0], edge_overflow[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNW = $clog2(MAX_EDGES + 1);
    localparam int NV  = maw_pkg::NV;
    localparam int VW  = maw_pkg::VW;
    localparam int NW  = maw_pkg::NW;
    localparam int CW  = maw_pkg::CW;
    localparam int TW  = maw_pkg::TW;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LOAD   = 4'd1;
    localparam logic [3:0] ST_CLOSE  = 4'd2;
    localparam logic [3:0] ST_CHECK  = 4'd3;
    localparam logic [3:0] ST_MIN    = 4'd4;
    localparam logic [3:0] ST_ADD    = 4'd5;
    localparam logic [3:0] ST_SUB    = 4'd6;
    localparam logic [3:0] ST_LABEL  = 4'd7;
    localparam logic [3:0] ST_UPD    = 4'd8;
    localparam logic [3:0] ST_RELAB  = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;

    localparam logic REG_VCOUNT = 1'b0;
    localparam logic REG_ROOT   = 1'b1;

    // edge memory
    maw_pkg::edge_rec_t edge_mem [MAX_EDGES];
    maw_pkg::edge_rec_t rd_reg;
    maw_pkg::edge_rec_t wr_data;
    logic [EW-1:0]      rd_addr;
    logic [EW-1:0]      wr_addr;
    logic               wr_en;

    logic [3:0]     state_reg, state_next;
    logic [CNW-1:0] idx_reg, idx_next;
    logic           pend_reg, pend_next;
    logic [EW-1:0]  paddr_reg, paddr_next;
    logic [VW-1:0]  vcnt_reg, vcnt_next;
    logic           first_reg, first_next;
    logic           ok_reg, ok_next;
    logic [VW-1:0]  root_reg, root_next;
    logic [NV-1:0]  active_reg, active_next;
    logic [CW-1:0]  min_val_reg [NV];
    logic [CW-1:0]  min_val_next [NV];
    logic [NV-1:0]  min_ok_reg, min_ok_next;
    logic [VW-1:0]  grp_reg [NV];
    logic [VW-1:0]  grp_next [NV];
    logic [TW-1:0]  total_reg, total_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           ovf_reg, ovf_next;
    logic [NW-1:0]  vc_reg, vc_next;
    logic [VW-1:0]  rv_reg, rv_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_reach_reg, out_reach_next;
    logic [TW-1:0]  out_total_reg, out_total_next;
    logic           out_ovf_reg, out_ovf_next;

    maw_pkg::clo_ctrl_t                clo_ctrl;
    logic [NV-1:0][NV-1:0]             rows;

    logic          in_accept;
    logic          in_cmd;
    logic [VW-1:0] in_from;
    logic [VW-1:0] in_to;
    logic [CW-1:0] in_weight;
    logic [NW-1:0] n_eff;
    logic [NV-1:0] n_mask;
    logic          sweep_issue;
    logic          sweep_done;
    logic [CW-1:0] head_min;
    logic [CW-1:0] sub_cost;
    logic [NV-1:0] root_bit;
    logic          all_reached;
    logic [NV-1:0] cand;
    logic [VW-1:0] cand_enc;
    logic [VW-1:0] rel_tail;
    logic [VW-1:0] rel_head;
    logic          cfg_wr;

    assign in_accept = s_tvalid && s_tready;
    assign in_cmd    = s_tuser[0];
    assign in_from   = s_tdata[3:0];
    assign in_to     = s_tdata[7:4];
    assign in_weight = s_tdata[39:8];

    always_comb
    begin
        priority if (vc_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (vc_reg > NW'(NV))
        begin
            n_eff = NW'(NV);
        end
        else
        begin
            n_eff = vc_reg;
        end
        for (int v = 0; v < NV; v++)
        begin
            n_mask[v] = (NW'(v) < n_eff);
        end
    end

    assign sweep_issue = (idx_reg < cnt_reg);
    assign sweep_done  = !sweep_issue && !pend_reg;
    assign rd_addr     = idx_reg[EW-1:0];

    assign head_min = min_ok_reg[rd_reg.head] ? min_val_reg[rd_reg.head] : '0;
    assign sub_cost = (rd_reg.head == root_reg) ? rd_reg.cost : rd_reg.cost - head_min;
    assign rel_tail = grp_reg[rd_reg.tail];
    assign rel_head = grp_reg[rd_reg.head];

    always_comb
    begin
        root_bit           = '0;
        root_bit[root_reg] = 1'b1;
        all_reached        = ((active_reg & ~(rows[root_reg] | root_bit)) == '0);
        for (int u = 0; u < NV; u++)
        begin
            cand[u] = active_reg[u] && ((VW'(u) == vcnt_reg)
                      || (rows[vcnt_reg][u] && rows[u][vcnt_reg]));
        end
        cand_enc = '0;
        for (int u = NV - 1; u >= 0; u--)
        begin
            if (cand[u])
            begin
                cand_enc = VW'(u);
            end
        end
    end

    maw_closure u_closure
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (clo_ctrl),
        .rows  (rows)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        paddr_next     = idx_reg[EW-1:0];
        vcnt_next      = vcnt_reg;
        first_next     = first_reg;
        ok_next        = ok_reg;
        root_next      = root_reg;
        active_next    = active_reg;
        min_val_next   = min_val_reg;
        min_ok_next    = min_ok_reg;
        grp_next       = grp_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_reach_next = out_reach_reg;
        out_total_next = out_total_reg;
        out_ovf_next   = out_ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = paddr_reg;
        wr_data        = rd_reg;
        clo_ctrl       = '0;
        s_tready       = (state_reg == ST_IDLE);

        if (state_reg == ST_LOAD || state_reg == ST_MIN || state_reg == ST_SUB
            || state_reg == ST_RELAB)
        begin
            pend_next = sweep_issue;
            if (sweep_issue)
            begin
                idx_next = idx_reg + CNW'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_cmd == CMD_ADD)
                    begin
                        if (in_from != in_to)
                        begin
                            if (cnt_reg == CNW'(MAX_EDGES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = cnt_reg[EW-1:0];
                                wr_data.live = 1'b1;
                                wr_data.tail = in_from;
                                wr_data.head = in_to;
                                wr_data.cost = in_weight;
                                cnt_next     = cnt_reg + CNW'(1);
                            end
                        end
                    end
                    else if (in_cmd == CMD_SOLVE)
                    begin
                        root_next   = rv_reg;
                        active_next = n_mask;
                        first_next  = 1'b1;
                        ok_next     = 1'b0;
                        total_next  = '0;
                        idx_next    = '0;
                        if ({1'b0, rv_reg} >= n_eff)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            clo_ctrl.clr = 1'b1;
                            state_next   = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD:
            begin
                if (pend_reg)
                begin
                    wr_en        = 1'b1;
                    wr_data.live = ({1'b0, rd_reg.tail} < n_eff)
                                   && ({1'b0, rd_reg.head} < n_eff);
                    clo_ctrl.set_en  = wr_data.live;
                    clo_ctrl.set_row = rd_reg.tail;
                    clo_ctrl.set_col = rd_reg.head;
                end
                if (sweep_done)
                begin
                    vcnt_next  = '0;
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                clo_ctrl.step_en = 1'b1;
                clo_ctrl.step_k  = vcnt_reg;
                vcnt_next        = vcnt_reg + VW'(1);
                if (vcnt_reg == VW'(NV - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (first_reg)
                begin
                    if (!all_reached)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        first_next  = 1'b0;
                        min_ok_next = '0;
                        idx_next    = '0;
                        state_next  = ST_MIN;
                    end
                end
                else if (all_reached)
                begin
                    ok_next    = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    vcnt_next  = '0;
                    state_next = ST_LABEL;
                end
            end
            ST_MIN:
            begin
                if (pend_reg && rd_reg.live && rd_reg.head != root_reg)
                begin
                    if (!min_ok_reg[rd_reg.head] || rd_reg.cost < min_val_reg[rd_reg.head])
                    begin
                        min_ok_next[rd_reg.head]  = 1'b1;
                        min_val_next[rd_reg.head] = rd_reg.cost;
                    end
                end
                if (sweep_done)
                begin
                    vcnt_next  = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (active_reg[vcnt_reg] && vcnt_reg != root_reg && min_ok_reg[vcnt_reg])
                begin
                    total_next = total_reg + TW'(min_val_reg[vcnt_reg]);
                end
                vcnt_next = vcnt_reg + VW'(1);
                if (vcnt_reg == VW'(NV - 1))
                begin
                    clo_ctrl.clr = 1'b1;
                    idx_next     = '0;
                    state_next   = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (pend_reg && rd_reg.live)
                begin
                    wr_en            = 1'b1;
                    wr_data.cost     = sub_cost;
                    clo_ctrl.set_en  = (sub_cost == '0);
                    clo_ctrl.set_row = rd_reg.tail;
                    clo_ctrl.set_col = rd_reg.head;
                end
                if (sweep_done)
                begin
                    vcnt_next  = '0;
                    state_next = ST_CLOSE;
                end
            end
            ST_LABEL:
            begin
                grp_next[vcnt_reg] = cand_enc;
                vcnt_next          = vcnt_reg + VW'(1);
                if (vcnt_reg == VW'(NV - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                root_next = grp_reg[root_reg];
                for (int v = 0; v < NV; v++)
                begin
                    active_next[v] = active_reg[v] && (grp_reg[v] == VW'(v));
                end
                idx_next   = '0;
                state_next = ST_RELAB;
            end
            ST_RELAB:
            begin
                if (pend_reg && rd_reg.live)
                begin
                    wr_en        = 1'b1;
                    wr_data.tail = rel_tail;
                    wr_data.head = rel_head;
                    wr_data.live = (rel_tail != rel_head);
                end
                if (sweep_done)
                begin
                    min_ok_next = '0;
                    idx_next    = '0;
                    state_next  = ST_MIN;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_reach_next = ok_reg;
                    out_total_next = ok_reg ? total_reg : '0;
                    out_ovf_next   = ovf_reg;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // edge memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            edge_mem[wr_addr] <= wr_data;
        end
        rd_reg <= edge_mem[rd_addr];
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        vc_next = vc_reg;
        rv_next = rv_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_VCOUNT: vc_next = pwdata[NW-1:0];
                REG_ROOT:   rv_next = pwdata[VW-1:0];
                default:    vc_next = vc_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_VCOUNT: prdata = {{(32 - NW){1'b0}}, vc_reg};
            REG_ROOT:   prdata = {{(32 - VW){1'b0}}, rv_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            vcnt_reg      <= '0;
            first_reg     <= 1'b0;
            ok_reg        <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            vc_reg        <= NW'(NV);
            rv_reg        <= '0;
            out_valid_reg <= 1'b0;
            min_ok_reg    <= '0;
            active_reg    <= '0;
            root_reg      <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            vcnt_reg      <= vcnt_next;
            first_reg     <= first_next;
            ok_reg        <= ok_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            vc_reg        <= vc_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
            min_ok_reg    <= min_ok_next;
            active_reg    <= active_next;
            root_reg      <= root_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg     <= paddr_next;
        min_val_reg   <= min_val_next;
        grp_reg       <= grp_next;
        out_reach_reg <= out_reach_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_total_reg};
    assign m_tuser  = {out_ovf_reg, out_reach_reg};

endmodule

### sv/maw_checker.sv
// ----------------------------------------------------------------------------
// maw_checker
// port level checks of the minimum arborescence weight block
// ----------------------------------------------------------------------------
module maw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        pready
);

    // held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    // unreachable graph reports zero weight
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 40'd0)
    else $error("non-zero weight on unreachable result");

    // a solve request makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("ready straight after a solve request");

    // a new result only comes from a solve in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready) && pready)
    else $error("result appeared while idle");

endmodule

bind min_arborescence_weight maw_checker u_maw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
